FILE: hdl/gbf_pkg.sv
// shared types and constants of the gb2312 font rom fetcher
`timescale 1ns / 1ps
`default_nettype none

package gbf_pkg;

    // input kinds
    localparam logic KIND_BEGIN = 1'b0;
    localparam logic KIND_TEXT  = 1'b1;

    // byte classes
    localparam logic [7:0] HANZI_LO   = 8'hB0;
    localparam logic [7:0] HANZI_HI   = 8'hF7;
    localparam logic [7:0] SYM_LO     = 8'hA1;
    localparam logic [7:0] SYM_HI     = 8'hA3;
    localparam logic [7:0] TRAIL_MIN  = 8'hA1;
    localparam logic [7:0] ASCII_LO   = 8'h20;
    localparam logic [7:0] ASCII_HI   = 8'h7E;
    localparam logic [7:0] END_BYTE   = 8'h00;

    // glyph table geometry
    localparam int          ROW_BITS     = 7;
    localparam int          IDX_BITS     = 13;
    localparam int          OFFSET_BITS  = 18;
    localparam logic [IDX_BITS-1:0] ROW_CELLS    = 13'd94;
    localparam logic [IDX_BITS-1:0] HANZI_SKIP   = 13'd846;
    localparam logic [7:0]  WIDE_STEP    = 8'd16;
    localparam logic [7:0]  NARROW_STEP  = 8'd8;
    localparam logic [5:0]  WIDE_LENGTH  = 6'd32;
    localparam logic [5:0]  NARROW_LENGTH = 6'd16;

    // configuration
    localparam int          CFG_ADDR_BITS  = 3;
    localparam logic        REG_CJK_BASE   = 1'b0;
    localparam logic        REG_ASCII_BASE = 1'b1;
    localparam logic [23:0] ASCII_BASE_RESET = 24'h03CF80;

    // rom command
    localparam logic [7:0] READ_OPCODE = 8'h03;
    localparam logic [1:0] BEAT_OPCODE = 2'd0;
    localparam logic [1:0] BEAT_ADDR_HI = 2'd1;
    localparam logic [1:0] BEAT_ADDR_MID = 2'd2;
    localparam logic [1:0] BEAT_ADDR_LO = 2'd3;

    // glyph queue
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [23:0] addr;
        logic        wide;
        logic [7:0]  column;
    } glyph_t;

endpackage

`default_nettype wire

FILE: hdl/gbf_if.sv
// text and rom command channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface gbf_text_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] text_byte;
    logic [7:0] start_column;

    modport source (output valid, kind, text_byte, start_column, input ready);
    modport sink   (input valid, kind, text_byte, start_column, output ready);
endinterface

interface gbf_cmd_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tx_byte;
    logic [23:0] glyph_address;
    logic [5:0]  read_length;
    logic [7:0]  glyph_column;
    logic        wide_glyph;
    logic        last;

    modport source (output valid, tx_byte, glyph_address, read_length, glyph_column,
                    wide_glyph, last, input ready);
    modport sink   (input valid, tx_byte, glyph_address, read_length, glyph_column,
                    wide_glyph, last, output ready);
endinterface

`default_nettype wire

FILE: hdl/gbf_front.sv
// text decoder: lead byte tracking, column tracking and glyph address
`timescale 1ns / 1ps
`default_nettype none

module gbf_front #(
    parameter int ADDR_BITS = 24
) (
    input  wire                 clk,
    input  wire                 rst_n,
    gbf_text_if.sink            text,
    input  wire [23:0]          cjk_base,
    input  wire [23:0]          ascii_base,
    output gbf_pkg::glyph_t     push_data,
    output logic                push_valid,
    input  wire                 push_ready
);

    logic                               lead_pending_reg, lead_pending_next;
    logic [7:0]                         lead_byte_reg, lead_byte_next;
    logic [7:0]                         column_reg, column_next;
    logic                               s1_valid_reg;
    logic [gbf_pkg::OFFSET_BITS-1:0]    s1_offset_reg, s1_offset_next;
    logic                               s1_wide_reg, s1_wide_next;
    logic [7:0]                         s1_column_reg;

    logic       in_fire;
    logic       is_text;
    logic       pair_hit;
    logic       is_lead;
    logic       is_print;
    logic       glyph_now;
    logic       hanzi;
    logic [gbf_pkg::ROW_BITS-1:0]   row;
    logic [gbf_pkg::ROW_BITS-1:0]   trail_idx;
    logic [gbf_pkg::IDX_BITS-1:0]   idx;
    logic [ADDR_BITS-1:0]           addr_full;

    assign text.ready = !s1_valid_reg || push_ready;
    assign in_fire    = text.valid && text.ready;
    assign is_text    = (text.kind == gbf_pkg::KIND_TEXT);

    always_comb
    begin
        pair_hit  = lead_pending_reg && (text.text_byte >= gbf_pkg::TRAIL_MIN);
        is_lead   = text.text_byte inside {[gbf_pkg::HANZI_LO:gbf_pkg::HANZI_HI],
                                           [gbf_pkg::SYM_LO:gbf_pkg::SYM_HI]};
        is_print  = text.text_byte inside {[gbf_pkg::ASCII_LO:gbf_pkg::ASCII_HI]};
        glyph_now = is_text && (pair_hit || (!is_lead && is_print));

        // double-byte index: row of 94 cells, hanzi after the symbol area
        hanzi     = (lead_byte_reg >= gbf_pkg::HANZI_LO);
        row       = hanzi ? gbf_pkg::ROW_BITS'(lead_byte_reg - gbf_pkg::HANZI_LO)
                          : gbf_pkg::ROW_BITS'(lead_byte_reg - gbf_pkg::SYM_LO);
        trail_idx = gbf_pkg::ROW_BITS'(text.text_byte - gbf_pkg::TRAIL_MIN);
        idx       = gbf_pkg::IDX_BITS'(row) * gbf_pkg::ROW_CELLS
                  + gbf_pkg::IDX_BITS'(trail_idx)
                  + (hanzi ? gbf_pkg::HANZI_SKIP : '0);

        s1_wide_next   = pair_hit;
        s1_offset_next = pair_hit
            ? {idx, 5'd0}
            : gbf_pkg::OFFSET_BITS'({gbf_pkg::ROW_BITS'(text.text_byte - gbf_pkg::ASCII_LO),
                                     4'd0});

        lead_pending_next = lead_pending_reg;
        lead_byte_next    = lead_byte_reg;
        column_next       = column_reg;
        if (!is_text)
        begin
            lead_pending_next = 1'b0;
            column_next       = text.start_column;
        end
        else
        begin
            lead_pending_next = !pair_hit && is_lead && (text.text_byte != gbf_pkg::END_BYTE);
            if (lead_pending_next)
                lead_byte_next = text.text_byte;
            if (glyph_now)
                column_next = column_reg + (pair_hit ? gbf_pkg::WIDE_STEP
                                                     : gbf_pkg::NARROW_STEP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_pending_reg <= 1'b0;
            lead_byte_reg    <= '0;
            column_reg       <= '0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                lead_pending_reg <= lead_pending_next;
                lead_byte_reg    <= lead_byte_next;
                column_reg       <= column_next;
            end
            if (text.ready)
                s1_valid_reg <= in_fire && glyph_now;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && glyph_now)
        begin
            s1_offset_reg <= s1_offset_next;
            s1_wide_reg   <= s1_wide_next;
            s1_column_reg <= column_reg;
        end
    end

    // base add, wraps at the rom address width
    assign addr_full = ADDR_BITS'(s1_offset_reg)
                     + ADDR_BITS'(s1_wide_reg ? cjk_base : ascii_base);

    assign push_valid       = s1_valid_reg;
    assign push_data.addr   = 24'(addr_full);
    assign push_data.wide   = s1_wide_reg;
    assign push_data.column = s1_column_reg;

endmodule

`default_nettype wire

FILE: hdl/gbf_queue.sv
// short glyph queue between decoder and command serializer
`timescale 1ns / 1ps
`default_nettype none

module gbf_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  gbf_pkg::glyph_t     push_data,
    input  wire                 push_valid,
    output logic                push_ready,
    output gbf_pkg::glyph_t     pop_data,
    output logic                pop_valid,
    input  wire                 pop_ready
);

    localparam int PTR_BITS = (gbf_pkg::QUEUE_DEPTH > 1) ? $clog2(gbf_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(gbf_pkg::QUEUE_DEPTH + 1);

    gbf_pkg::glyph_t        slot_reg [gbf_pkg::QUEUE_DEPTH];
    logic [PTR_BITS-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0]    count_reg;
    logic                   push_fire, pop_fire;

    assign push_ready = (count_reg != CNT_BITS'(gbf_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (push_fire)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(gbf_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            if (pop_fire)
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(gbf_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            if (push_fire && !pop_fire)
                count_reg <= count_reg + 1'b1;
            else if (pop_fire && !push_fire)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/gbf_back.sv
// command serializer: four rom beats per glyph
`timescale 1ns / 1ps
`default_nettype none

module gbf_back (
    input  wire                 clk,
    input  wire                 rst_n,
    input  gbf_pkg::glyph_t     pop_data,
    input  wire                 pop_valid,
    output logic                pop_ready,
    gbf_cmd_if.source           cmd
);

    logic               busy_reg;
    logic [1:0]         beat_reg;
    gbf_pkg::glyph_t    glyph_reg;
    logic               out_fire;
    logic               last_beat;
    logic               load;

    assign last_beat = (beat_reg == gbf_pkg::BEAT_ADDR_LO);
    assign out_fire  = cmd.valid && cmd.ready;
    assign pop_ready = !busy_reg || (out_fire && last_beat);
    assign load      = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            beat_reg <= gbf_pkg::BEAT_OPCODE;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                beat_reg <= gbf_pkg::BEAT_OPCODE;
            end
            else if (out_fire)
            begin
                if (last_beat)
                    busy_reg <= 1'b0;
                beat_reg <= beat_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            glyph_reg <= pop_data;
    end

    always_comb
    begin
        case (beat_reg)
            gbf_pkg::BEAT_OPCODE:   cmd.tx_byte = gbf_pkg::READ_OPCODE;
            gbf_pkg::BEAT_ADDR_HI:  cmd.tx_byte = glyph_reg.addr[23:16];
            gbf_pkg::BEAT_ADDR_MID: cmd.tx_byte = glyph_reg.addr[15:8];
            gbf_pkg::BEAT_ADDR_LO:  cmd.tx_byte = glyph_reg.addr[7:0];
            default:                cmd.tx_byte = gbf_pkg::READ_OPCODE;
        endcase
    end

    assign cmd.valid         = busy_reg;
    assign cmd.glyph_address = glyph_reg.addr;
    assign cmd.glyph_column  = glyph_reg.column;
    assign cmd.wide_glyph    = glyph_reg.wide;
    assign cmd.last          = last_beat;
    assign cmd.read_length   = !last_beat ? 6'd0
                             : (glyph_reg.wide ? gbf_pkg::WIDE_LENGTH
                                               : gbf_pkg::NARROW_LENGTH);

endmodule

`default_nettype wire

FILE: hdl/gb2312_font_rom_fetcher.sv
// top level of the gb2312 font rom fetcher
`timescale 1ns / 1ps
`default_nettype none

// Turns a GB2312/ASCII text stream, one byte per beat on the text channel,
// into font ROM read commands on the rom_cmd channel. A hanzi or symbol pair
// (lead byte then trail byte 0xA1 or above) gives one 16x16 glyph, a printable
// ASCII byte gives one 8x16 glyph, and every glyph produces four command
// beats: read opcode 0x03, then address bits 23..16, 15..8, 7..0, with last
// and the read length (32 or 16) on the fourth beat. A kind 0 beat sets the
// start column; byte 0 ends a string. Rate: an item that makes no glyph is
// taken every cycle while the decode stage is empty or the glyph queue has
// room; the text side runs ahead into a two-entry glyph queue while each
// glyph's four command beats drain. A text beat passes the decode stage, the
// base add into the queue and the serializer load before its first command
// beat. cjk_base sits at byte address 0 and ascii_base at byte address 4 of
// the APB port; the user must write both only while the block is idle, which
// the block itself does not enforce. ADDR_BITS sets the width at which
// the glyph address wraps; only its low 24 bits are shown and sent.

module gb2312_font_rom_fetcher #(
    parameter int ADDR_BITS = 24
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // configuration
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire [gbf_pkg::CFG_ADDR_BITS-1:0]    paddr,
    input  wire [31:0]                          pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // channels
    gbf_text_if.sink                            text,
    gbf_cmd_if.source                           rom_cmd
);

    logic [23:0]        cjk_base_reg;
    logic [23:0]        ascii_base_reg;
    logic               cfg_write;

    gbf_pkg::glyph_t    push_data;
    logic               push_valid;
    logic               push_ready;
    gbf_pkg::glyph_t    pop_data;
    logic               pop_valid;
    logic               pop_ready;

    // apb register file, zero wait states
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cjk_base_reg   <= '0;
            ascii_base_reg <= gbf_pkg::ASCII_BASE_RESET;
        end
        else if (cfg_write)
        begin
            // registers decode on the word address bit only
            if (paddr[2] == gbf_pkg::REG_CJK_BASE)
                cjk_base_reg <= pwdata[23:0];
            else
                ascii_base_reg <= pwdata[23:0];
        end
    end

    assign prdata = (paddr[2] == gbf_pkg::REG_ASCII_BASE) ? {8'd0, ascii_base_reg}
                                                          : {8'd0, cjk_base_reg};

    // front: byte classification, lead/column state, address compute
    gbf_front #(
        .ADDR_BITS  (ADDR_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .cjk_base   (cjk_base_reg),
        .ascii_base (ascii_base_reg),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // decouples decoding from the four-beat command drain
    gbf_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (push_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // back: opcode and address beats toward the rom
    gbf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .cmd        (rom_cmd)
    );

endmodule

`default_nettype wire

FILE: tb/gbf_rom_cmd_checker.sv
// checker for the gb2312 font rom fetcher: predicts rom command beats and compares them
`timescale 1ns / 1ps

module gbf_rom_cmd_checker (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              psel,
    input  wire                              penable,
    input  wire                              pwrite,
    input  wire [gbf_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  wire [31:0]                       pwdata,
    input  wire                              pready,
    gbf_text_if                              text,
    gbf_cmd_if                               rom_cmd,
    output int                               mismatches,
    output int                               pending_beats,
    output int                               wide_glyphs,
    output int                               narrow_glyphs
);

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic [23:0] glyph_address;
        logic [5:0]  read_length;
        logic [7:0]  glyph_column;
        logic        wide_glyph;
        logic        last;
    } rom_beat_t;

    rom_beat_t   awaited_beats[$];
    logic [23:0] cjk_base;
    logic [23:0] ascii_base;
    logic        lead_held;
    logic [7:0]  lead_byte;
    logic [7:0]  next_column;

    task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("ERROR %0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // four beats per glyph: opcode, then address high to low
    task queue_glyph(input logic [31:0] offset, input logic wide);
        logic [23:0] addr;
        logic [2:0]  k;
        rom_beat_t   beat;
        addr = offset[23:0];
        for (k = 0; k < 4; k++)
        begin
            case (k[1:0])
                gbf_pkg::BEAT_OPCODE:   beat.tx_byte = gbf_pkg::READ_OPCODE;
                gbf_pkg::BEAT_ADDR_HI:  beat.tx_byte = addr[23:16];
                gbf_pkg::BEAT_ADDR_MID: beat.tx_byte = addr[15:8];
                default:                beat.tx_byte = addr[7:0];
            endcase
            beat.glyph_address = addr;
            beat.last          = (k[1:0] == gbf_pkg::BEAT_ADDR_LO);
            beat.read_length   = !beat.last ? 6'd0
                               : (wide ? gbf_pkg::WIDE_LENGTH : gbf_pkg::NARROW_LENGTH);
            beat.glyph_column  = next_column;
            beat.wide_glyph    = wide;
            awaited_beats.push_back(beat);
        end
        next_column = next_column + (wide ? gbf_pkg::WIDE_STEP : gbf_pkg::NARROW_STEP);
        if (wide)
            wide_glyphs++;
        else
            narrow_glyphs++;
    endtask

    task decode_text(input logic kind, input logic [7:0] b, input logic [7:0] col);
        int unsigned row;
        int unsigned glyph_idx;
        if (kind == gbf_pkg::KIND_BEGIN)
        begin
            next_column = col;
            lead_held   = 1'b0;
            return;
        end
        if (lead_held)
        begin
            lead_held = 1'b0;
            if (b >= gbf_pkg::TRAIL_MIN)
            begin
                if (lead_byte >= gbf_pkg::HANZI_LO)
                    row = 32'(lead_byte - gbf_pkg::HANZI_LO);
                else
                    row = 32'(lead_byte - gbf_pkg::SYM_LO);
                glyph_idx = row * 32'(gbf_pkg::ROW_CELLS) + 32'(b - gbf_pkg::TRAIL_MIN);
                if (lead_byte >= gbf_pkg::HANZI_LO)
                    glyph_idx = glyph_idx + 32'(gbf_pkg::HANZI_SKIP);
                queue_glyph(glyph_idx * 32'(gbf_pkg::WIDE_LENGTH) + 32'(cjk_base), 1'b1);
                return;
            end
            // lead dropped, byte judged on its own below
        end
        if (b == gbf_pkg::END_BYTE)
            return;
        if ((b >= gbf_pkg::HANZI_LO && b <= gbf_pkg::HANZI_HI)
            || (b >= gbf_pkg::SYM_LO && b <= gbf_pkg::SYM_HI))
        begin
            lead_held = 1'b1;
            lead_byte = b;
        end
        else if (b >= gbf_pkg::ASCII_LO && b <= gbf_pkg::ASCII_HI)
            queue_glyph(32'(b - gbf_pkg::ASCII_LO) * 32'(gbf_pkg::NARROW_LENGTH)
                        + 32'(ascii_base), 1'b0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        rom_beat_t want;
        if (!rst_n)
        begin
            awaited_beats.delete();
            cjk_base      = '0;
            ascii_base    = gbf_pkg::ASCII_BASE_RESET;
            lead_held     = 1'b0;
            lead_byte     = '0;
            next_column   = '0;
            mismatches    = 0;
            pending_beats = 0;
            wide_glyphs   = 0;
            narrow_glyphs = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == gbf_pkg::REG_ASCII_BASE)
                    ascii_base = pwdata[23:0];
                else
                    cjk_base = pwdata[23:0];
            end
            if (rom_cmd.valid && rom_cmd.ready)
            begin
                if (awaited_beats.size() == 0)
                    report_mismatch("command beat with none awaited, tx_byte",
                                    32'(rom_cmd.tx_byte), 32'd0);
                else
                begin
                    want = awaited_beats.pop_front();
                    if (rom_cmd.tx_byte !== want.tx_byte)
                        report_mismatch("tx_byte", 32'(rom_cmd.tx_byte), 32'(want.tx_byte));
                    if (rom_cmd.glyph_address !== want.glyph_address)
                        report_mismatch("glyph_address", 32'(rom_cmd.glyph_address),
                                        32'(want.glyph_address));
                    if (rom_cmd.read_length !== want.read_length)
                        report_mismatch("read_length", 32'(rom_cmd.read_length),
                                        32'(want.read_length));
                    if (rom_cmd.glyph_column !== want.glyph_column)
                        report_mismatch("glyph_column", 32'(rom_cmd.glyph_column),
                                        32'(want.glyph_column));
                    if (rom_cmd.wide_glyph !== want.wide_glyph)
                        report_mismatch("wide_glyph", 32'(rom_cmd.wide_glyph),
                                        32'(want.wide_glyph));
                    if (rom_cmd.last !== want.last)
                        report_mismatch("last", 32'(rom_cmd.last), 32'(want.last));
                end
            end
            if (text.valid && text.ready)
                decode_text(text.kind, text.text_byte, text.start_column);
            pending_beats = awaited_beats.size();
        end
    end

endmodule

FILE: tb/tb_gb2312_font_rom_fetcher.sv
// testbench top of the gb2312 font rom fetcher: stimulus, idling and verdict
`timescale 1ns / 1ps

module tb_gb2312_font_rom_fetcher;

    // cycles with no beat on either channel before the run is declared hung;
    // slowest legal stretch is a drain plus settle plus a register write,
    // far below this even with every command beat given the longest stall drawn
    localparam int HANG_LIMIT = 2000;
    // settle time before a register write: three stage pipeline plus margin
    localparam int SETTLE_CYCLES = 8;
    // counted text beats per random phase
    localparam int PHASE_BEATS = 75;

    logic                              clk;
    logic                              rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [gbf_pkg::CFG_ADDR_BITS-1:0] paddr;
    logic [31:0]                       pwdata;
    wire  [31:0]                       prdata;
    wire                               pready;

    gbf_text_if text ();
    gbf_cmd_if  rom_cmd ();

    int mismatches;
    int pending_beats;
    int wide_glyphs;
    int narrow_glyphs;

    // run statistics for the summary
    int text_beats;
    int strings;
    int settings;
    int counted;

    // burst flags: while set, that side draws no random idle gap
    bit text_calm;
    bit cmd_calm;

    gb2312_font_rom_fetcher i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .text    (text),
        .rom_cmd (rom_cmd)
    );

    gbf_rom_cmd_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .text          (text),
        .rom_cmd       (rom_cmd),
        .mismatches    (mismatches),
        .pending_beats (pending_beats),
        .wide_glyphs   (wide_glyphs),
        .narrow_glyphs (narrow_glyphs)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // random idle length per beat, with occasional runs of back-to-back beats
    function automatic int draw_gap(inout bit calm);
        if ($urandom_range(0, 31) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 6);
    endfunction

    // one text beat; entered and left at a falling edge, valid left high so
    // a following beat with no gap keeps it up without a glitch
    task send(input logic kind, input logic [7:0] b, input logic [7:0] col);
        int gap;
        gap = draw_gap(text_calm);
        if (gap > 0)
        begin
            text.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text.valid        <= 1'b1;
        text.kind         <= kind;
        text.text_byte    <= b;
        text.start_column <= col;
        do
            @(posedge clk);
        while (!text.ready);
        @(negedge clk);
        text_beats++;
    endtask

    // start_column is a don't care on text beats and text_byte on begin beats,
    // both get random values so every payload bit moves
    task send_text(input logic [7:0] b);
        send(gbf_pkg::KIND_TEXT, b, 8'($urandom_range(0, 255)));
    endtask

    task begin_string(input logic [7:0] col);
        send(gbf_pkg::KIND_BEGIN, 8'($urandom_range(0, 255)), col);
        strings++;
    endtask

    // hold the text side until every awaited command beat has come out
    task wait_drained();
        text.valid <= 1'b0;
        @(negedge clk);
        while (pending_beats != 0)
            @(negedge clk);
    endtask

    // apb write: setup then access, register lands at the access edge
    task write_reg(input logic idx, input logic [23:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {8'h00, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // registers change only with the pipeline empty
    task set_bases(input logic [23:0] cjk, input logic [23:0] ascii);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(gbf_pkg::REG_CJK_BASE, cjk);
        write_reg(gbf_pkg::REG_ASCII_BASE, ascii);
        settings++;
    endtask

    function automatic logic [7:0] any_lead();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(gbf_pkg::SYM_LO, gbf_pkg::SYM_HI));
        return 8'($urandom_range(gbf_pkg::HANZI_LO, gbf_pkg::HANZI_HI));
    endfunction

    // one string: begin beat, a mix of glyphs and odd bytes, usually an end byte
    task send_string();
        int chars;
        int pick;
        begin_string(8'($urandom_range(0, 255)));
        chars = $urandom_range(1, 10);
        repeat (chars)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 35)
            begin
                // hanzi pair, any trail from the first row cell up
                send_text(8'($urandom_range(gbf_pkg::HANZI_LO, gbf_pkg::HANZI_HI)));
                send_text(8'($urandom_range(gbf_pkg::TRAIL_MIN, 8'hFF)));
                counted += 2;
            end
            else if (pick < 48)
            begin
                // symbol pair
                send_text(8'($urandom_range(gbf_pkg::SYM_LO, gbf_pkg::SYM_HI)));
                send_text(8'($urandom_range(gbf_pkg::TRAIL_MIN, 8'hFF)));
                counted += 2;
            end
            else if (pick < 78)
            begin
                send_text(8'($urandom_range(gbf_pkg::ASCII_LO, gbf_pkg::ASCII_HI)));
                counted++;
            end
            else if (pick < 86)
            begin
                // lead with a bad trail: dropped, trail judged alone (end byte too)
                send_text(any_lead());
                send_text(8'($urandom_range(0, gbf_pkg::TRAIL_MIN - 1)));
                counted += 2;
            end
            else if (pick < 92)
                // restart in mid string, also clears a held lead
                begin_string(8'($urandom_range(0, 255)));
            else
                // raw noise over the whole field space
                send(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 4) != 0)
            send_text(gbf_pkg::END_BYTE);
    endtask

    task run_phase(input int beats);
        counted = 0;
        while (counted < beats)
        begin
            send_string();
            // now and then the sender waits for the command side to empty
            if ($urandom_range(0, 39) == 0)
                wait_drained();
        end
    endtask

    // command side: random stall before each beat, bursts with none
    initial
    begin
        rom_cmd.ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            int gap;
            gap = draw_gap(cmd_calm);
            if (gap > 0)
            begin
                rom_cmd.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            rom_cmd.ready <= 1'b1;
            do
                @(posedge clk);
            while (!rom_cmd.valid);
            @(negedge clk);
        end
    end

    // hang detector: any beat on either channel restarts the count
    initial
    begin
        int idle;
        idle = 0;
        while (idle < HANG_LIMIT)
        begin
            @(posedge clk);
            if ((text.valid && text.ready) || (rom_cmd.valid && rom_cmd.ready))
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no beat for %0d cycles, %0d command beats outstanding",
                 HANG_LIMIT, pending_beats);
        $display("gb2312_font_rom_fetcher verification failed");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        text.valid        = 1'b0;
        text.kind         = gbf_pkg::KIND_TEXT;
        text.text_byte    = '0;
        text.start_column = '0;
        text_beats        = 0;
        strings           = 0;
        settings          = 1;
        counted           = 0;
        text_calm         = 1'b0;
        cmd_calm          = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part under the reset bases
        // start near the top so narrow glyphs wrap the column
        begin_string(8'hF8);
        send_text(gbf_pkg::ASCII_LO);
        send_text(gbf_pkg::ASCII_HI);
        // first and last symbol rows, first and last trail
        send_text(gbf_pkg::SYM_LO);
        send_text(gbf_pkg::TRAIL_MIN);
        send_text(gbf_pkg::SYM_HI);
        send_text(8'hFF);
        // first and last hanzi rows
        send_text(gbf_pkg::HANZI_LO);
        send_text(gbf_pkg::TRAIL_MIN);
        send_text(gbf_pkg::HANZI_HI);
        send_text(8'hFF);
        // unmatched lead then an ascii letter, which still prints
        send_text(gbf_pkg::HANZI_LO);
        send_text(8'h41);
        // lead then end of string
        send_text(8'hC0);
        send_text(gbf_pkg::END_BYTE);
        // skipped bytes just outside the classes
        send_text(gbf_pkg::ASCII_HI + 8'd1);
        send_text(gbf_pkg::HANZI_HI + 8'd1);
        // lead with trail one below the minimum: both dropped
        send_text(gbf_pkg::HANZI_LO);
        send_text(gbf_pkg::TRAIL_MIN - 8'd1);
        // begin beat while a lead is held clears it
        send_text(8'hD0);
        begin_string(8'h00);
        send_text(gbf_pkg::SYM_LO);
        send_text(gbf_pkg::TRAIL_MIN);
        // a lead byte taken as trail still makes a glyph
        send_text(8'hB5);
        send_text(8'hB5);
        wait_drained();

        run_phase(PHASE_BEATS);
        // largest bases: address sum wraps
        set_bases(24'hFFFFFF, 24'hFFFFFF);
        run_phase(PHASE_BEATS);
        set_bases(24'h000000, 24'h000000);
        run_phase(PHASE_BEATS);
        set_bases(24'($urandom_range(0, 24'hFFFFFF)), 24'($urandom_range(0, 24'hFFFFFF)));
        run_phase(PHASE_BEATS);

        // all stimulus in: drain, then give stray beats time to show up
        wait_drained();
        repeat (SETTLE_CYCLES + 2) @(negedge clk);

        $display("run covered %0d text beats in %0d strings under %0d base settings",
                 text_beats, strings, settings);
        $display("command side checked %0d wide and %0d narrow glyphs, %0d mismatches",
                 wide_glyphs, narrow_glyphs, mismatches);
        if (mismatches == 0)
            $display("gb2312_font_rom_fetcher verification clean");
        else
            $display("gb2312_font_rom_fetcher verification failed");
        $finish;
    end

endmodule
